// ----- rtl/core/ack_tracking_retransmit_table_top_macros.svh -----
// Assertion macros for the retransmit table checker
`ifndef ACK_TRACKING_RETRANSMIT_TABLE_TOP_MACROS_SVH
`define ACK_TRACKING_RETRANSMIT_TABLE_TOP_MACROS_SVH
// a implies b in the same cycle
`define ATRT_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: check failed");
// a implies b in the next cycle
`define ATRT_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: check failed");
`endif

// ----- rtl/core/atrt_pkg.sv -----
package atrt_pkg;
    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam logic [4:0]  MAX_RESULTS     = 5'd16;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_DATA = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_RECORDED = 3'd1;
    localparam logic [2:0] ACT_RETX     = 3'd2;
    localparam logic [2:0] ACT_DELIVER  = 3'd3;
    localparam logic [2:0] ACT_BAD_CK   = 3'd4;
    localparam logic [2:0] ACT_NOT_OURS = 3'd5;
    localparam logic [2:0] ACT_ACKED    = 3'd6;

    localparam logic [1:0] REG_OWN   = 2'd0;
    localparam logic [1:0] REG_BCAST = 2'd1;
    localparam logic [1:0] REG_TMO   = 2'd2;

    localparam logic [7:0]  OWN_RST   = 8'd39;
    localparam logic [7:0]  BCAST_RST = 8'd255;
    localparam logic [31:0] TMO_RST   = 32'd2000000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [7:0]  msg_id;
        logic [4:0]  payload_length;
        logic [7:0]  rx_checksum;
        logic [31:0] now_us;
    } t_req;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] entry_index;
        logic [7:0] out_dest;
        logic [7:0] out_src;
        logic [7:0] out_id;
        logic [7:0] out_checksum;
        logic [4:0] cleared_count;
        logic       last;
    } t_res;

    // classified item handed from front to back
    typedef struct packed {
        logic       scan;      // ack or tick: needs a table scan
        logic       is_tick;
        logic       is_send;
        t_res       res;       // ready-made result for non-scan items
        logic [7:0] key_dest;
        logic [7:0] key_id;
        logic [31:0] now_us;
    } t_cmd;

    // configuration snapshot
    typedef struct packed {
        logic [7:0]  own;
        logic [7:0]  bcast;
        logic [31:0] tmo;
    } t_cfg;

    function automatic logic [7:0] chk(input logic [7:0] d, input logic [7:0] s,
                                       input logic [4:0] len);
        chk = d + s + {3'd0, len} - 8'd1;
    endfunction
endpackage

// ----- rtl/core/atrt_front.sv -----
module atrt_front
    import atrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    input  t_cfg i_cfg,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);
    localparam int unsigned QW = $clog2(QUEUE_DEPTH);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [QW-1:0]    r_wp, r_rp;
    logic [QW:0]      r_cnt;
    t_cmd             n_cmd;

    // classify the request and build its single result where no scan is needed
    always_comb begin
        n_cmd          = '0;
        n_cmd.key_dest = i_req.src_addr;
        n_cmd.key_id   = i_req.msg_id;
        n_cmd.now_us   = i_req.now_us;
        n_cmd.res.last = 1'b1;
        unique case (i_req.req_type)
            REQ_SEND: begin
                n_cmd.is_send          = 1'b1;
                n_cmd.key_dest         = i_req.dest_addr;
                n_cmd.res.action       = ACT_RECORDED;
                n_cmd.res.out_dest     = i_req.dest_addr;
                n_cmd.res.out_src      = i_cfg.own;
                n_cmd.res.out_id       = i_req.msg_id;
                n_cmd.res.out_checksum = chk(i_req.dest_addr, i_cfg.own,
                                             i_req.payload_length);
            end
            REQ_ACK: n_cmd.scan = 1'b1;
            REQ_DATA: begin
                if (chk(i_req.dest_addr, i_req.src_addr, i_req.payload_length)
                        != i_req.rx_checksum) begin
                    n_cmd.res.action = ACT_BAD_CK;
                end else if (i_req.dest_addr != i_cfg.own &&
                             i_req.dest_addr != i_cfg.bcast) begin
                    n_cmd.res.action = ACT_NOT_OURS;
                end else begin
                    n_cmd.res.action   = ACT_DELIVER;
                    n_cmd.res.out_dest = i_req.src_addr;
                    n_cmd.res.out_src  = i_req.dest_addr;
                    n_cmd.res.out_id   = i_req.msg_id;
                end
            end
            default: begin
                n_cmd.scan    = 1'b1;
                n_cmd.is_tick = 1'b1;
            end
        endcase
    end

    assign o_full  = (r_cnt == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    // command queue
    always_ff @(posedge i_clk) begin
        if (i_valid) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_valid) r_wp <= r_wp + 1'b1;
            if (i_pop)   r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(i_valid) - (QW+1)'(i_pop);
        end
    end
endmodule

// ----- rtl/core/atrt_back.sv -----
module atrt_back
    import atrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_cmd,
    input  t_cfg i_cfg,
    output logic o_pop,
    output logic o_valid,
    output t_res o_res
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_CLOSE = 2'd3;

    // table memory: dest, id, time per slot
    logic [47:0]          r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_wait;
    logic [AW-1:0]        r_wpos;
    logic [1:0]           r_st;
    logic [AW-1:0]        r_idx, r_ridx;
    logic [47:0]          r_rd;
    logic [4:0]           r_cnt;
    logic                 r_any;
    logic                 r_rlast;
    logic                 r_valid;
    t_res                 r_res;
    t_res                 r_pend;
    t_cmd                 r_cmd;
    t_res                 n_res;
    t_res                 n_close;
    logic [4:0]           n_cnt;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [47:0]          mem_wd;
    logic                 hit, due, due_ok;
    logic [31:0]          age;

    assign o_pop   = (r_st == ST_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    assign age    = r_cmd.now_us - r_rd[31:0];
    assign hit    = r_wait[r_ridx] && r_rd[47:40] == r_cmd.key_dest &&
                    r_rd[39:32] == r_cmd.key_id;
    assign due    = r_wait[r_ridx] && age > i_cfg.tmo;
    // beyond the result limit the slot stays untouched for a later tick
    assign due_ok = due && (r_cnt != MAX_RESULTS);

    // result of a non-scan item, count and closing retransmit
    always_comb begin
        n_res = i_cmd.res;
        if (i_cmd.is_send) n_res.entry_index = 4'(r_wpos);
        n_cnt = (r_cnt == MAX_RESULTS) ? r_cnt : r_cnt + 5'(hit);
        n_close      = r_pend;
        n_close.last = 1'b1;
    end

    // memory write: send or timer restart
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wpos;
        mem_wd = {i_cmd.key_dest, i_cmd.key_id, i_cmd.now_us};
        if (o_pop && i_cmd.is_send) begin
            mem_we = 1'b1;
        end else if (r_st == ST_EVAL && r_cmd.is_tick && due_ok) begin
            mem_we = 1'b1;
            mem_wa = r_ridx;
            mem_wd = {r_rd[47:32], r_cmd.now_us};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[r_idx];
    end

    // scan sequencer: read a slot in the scan state, evaluate it in the eval state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_wait  <= '0;
            r_wpos  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_res <= n_res;
                        if (i_cmd.scan) begin
                            r_st  <= ST_SCAN;
                            r_idx <= '0;
                            r_cnt <= '0;
                            r_any <= 1'b0;
                        end else begin
                            r_valid <= 1'b1;
                            if (i_cmd.is_send) begin
                                r_wait[r_wpos] <= 1'b1;
                                r_wpos <= (r_wpos == LAST_IDX) ? '0 : r_wpos + 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    r_ridx  <= r_idx;
                    r_rlast <= (r_idx == LAST_IDX);
                    r_idx   <= r_idx + 1'b1;
                    r_st    <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (r_cmd.is_tick) begin
                        // a retransmit waits for the next due slot or the close
                        if (due_ok) begin
                            r_any  <= 1'b1;
                            r_cnt  <= r_cnt + 5'd1;
                            r_pend <= '{action: ACT_RETX, entry_index: 4'(r_ridx),
                                        out_dest: r_rd[47:40], out_src: i_cfg.own,
                                        out_id: r_rd[39:32], out_checksum: 8'd0,
                                        cleared_count: 5'd0, last: 1'b0};
                            if (r_any) begin
                                r_valid <= 1'b1;
                                r_res   <= r_pend;
                            end
                        end
                        r_st <= r_rlast ? ST_CLOSE : ST_SCAN;
                    end else begin
                        if (hit) r_wait[r_ridx] <= 1'b0;
                        if (r_rlast) begin
                            r_valid <= 1'b1;
                            r_res   <= '{action: ACT_ACKED, cleared_count: n_cnt,
                                         last: 1'b1, default: '0};
                        end
                        r_cnt <= n_cnt;
                        r_st  <= r_rlast ? ST_IDLE : ST_SCAN;
                    end
                end
                ST_CLOSE: begin
                    // final item of a tick: pending retransmit or none due
                    r_valid <= 1'b1;
                    if (r_any) begin
                        r_res <= n_close;
                    end else begin
                        r_res <= '{action: ACT_NONE, last: 1'b1, default: '0};
                    end
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/core/ack_tracking_retransmit_table_top.sv -----
// Channel   | Direction | Handshake                  | Payload
// request   | in        | i_start && !o_busy         | i_req  (t_req)
// result    | out       | o_res_valid, one cycle     | o_res  (t_res)
// config    | in        | psel & penable & pwrite    | pwdata, paddr
// Send and data items are queued and, once popped, give a registered result.
// Ack and tick items scan the slots one at a time, each read in the scan state
// and evaluated in the eval state through the single read port of the slot
// memory: an ack result follows the last slot, a tick's last item the close state.
// Synchronous active-low reset clears waiting marks and the write position.
// The receiver cannot stall; o_busy holds off items while the queue is full.
module ack_tracking_retransmit_table_top
    import atrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    logic q_full, q_empty, pop, accept;
    t_cmd cmd;

    assign pready = 1'b1;
    assign o_busy = q_full;
    assign accept = i_start && !o_busy;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{own: OWN_RST, bcast: BCAST_RST, tmo: TMO_RST};
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_OWN:   r_cfg.own   <= pwdata[7:0];
                REG_BCAST: r_cfg.bcast <= pwdata[7:0];
                REG_TMO:   r_cfg.tmo   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OWN:   prdata = {24'd0, r_cfg.own};
            REG_BCAST: prdata = {24'd0, r_cfg.bcast};
            REG_TMO:   prdata = r_cfg.tmo;
            default:   prdata = '0;
        endcase
    end

    atrt_front u_front (
        .i_clk, .i_rst_n, .i_valid(accept), .i_req, .i_cfg(r_cfg),
        .i_pop(pop), .o_full(q_full), .o_empty(q_empty), .o_cmd(cmd)
    );

    atrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_cmd(cmd), .i_cfg(r_cfg),
        .o_pop(pop), .o_valid(o_res_valid), .o_res(o_res)
    );
endmodule

// ----- rtl/core/atrt_checker.sv -----
`include "ack_tracking_retransmit_table_top_macros.svh"
module atrt_checker
    import atrt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_res_valid,
    input t_res o_res,
    input logic pready
);
    `ATRT_ASSERT_IMP(a_one_shot_last, i_clk, i_rst_n,
        o_res_valid && (o_res.action != ACT_RETX), o_res.last)
    `ATRT_ASSERT_IMP(a_count_range, i_clk, i_rst_n,
        o_res_valid && o_res.action == ACT_ACKED, o_res.cleared_count <= 5'd16)
    `ATRT_ASSERT_NXT(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind ack_tracking_retransmit_table_top atrt_checker u_chk (
    .i_clk, .i_rst_n, .o_res_valid, .o_res, .pready
);

// ----- bench/ack_tracking_retransmit_table_top_tb.sv -----
`timescale 1ns / 100ps

module ack_tracking_retransmit_table_top_tb;
    import atrt_pkg::*;

    localparam int DEPTH = 16;
    localparam int MAX_RETX = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_req        i_req;
    logic        o_res_valid;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ack_tracking_retransmit_table_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req(i_req), .o_res_valid(o_res_valid), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]  tbl_dest [DEPTH];
    logic [7:0]  tbl_id [DEPTH];
    logic [31:0] tbl_time [DEPTH];
    logic        tbl_waiting [DEPTH];
    logic [3:0]  wr_pos;
    logic [7:0]  cfg_own;
    logic [7:0]  cfg_bcast;
    logic [31:0] cfg_tmo;

    t_res        expected_results [$];
    int          n_errors;
    logic [7:0]  sent_dest [$];
    logic [7:0]  sent_id [$];

    // directed rows
    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_row;
    t_row rows [$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] csum(logic [7:0] d, logic [7:0] s, logic [4:0] len);
        logic [7:0] r;
        r = d + s + 8'(len) - 8'd1;
        return r;
    endfunction

    function automatic t_res blank_res();
        t_res r;
        r = '0;
        return r;
    endfunction

    // work out the result items of one request and update the table
    task automatic predict_request(input t_req q);
        t_res r;
        int   n;
        int   cnt;
        begin
            n = 0;
            case (q.req_type)
                REQ_SEND: begin
                    r = blank_res();
                    r.action = ACT_RECORDED;
                    r.entry_index = wr_pos;
                    r.out_dest = q.dest_addr;
                    r.out_src = cfg_own;
                    r.out_id = q.msg_id;
                    r.out_checksum = csum(q.dest_addr, cfg_own, q.payload_length);
                    r.last = 1'b1;
                    tbl_dest[wr_pos] = q.dest_addr;
                    tbl_id[wr_pos] = q.msg_id;
                    tbl_time[wr_pos] = q.now_us;
                    tbl_waiting[wr_pos] = 1'b1;
                    wr_pos = wr_pos + 4'd1;
                    expected_results.push_back(r);
                end
                REQ_ACK: begin
                    cnt = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (tbl_waiting[i] && tbl_dest[i] == q.src_addr &&
                            tbl_id[i] == q.msg_id) begin
                            tbl_waiting[i] = 1'b0;
                            cnt++;
                        end
                    end
                    r = blank_res();
                    r.action = ACT_ACKED;
                    r.cleared_count = 5'(cnt);
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                REQ_DATA: begin
                    r = blank_res();
                    if (csum(q.dest_addr, q.src_addr, q.payload_length) != q.rx_checksum)
                        r.action = ACT_BAD_CK;
                    else if (q.dest_addr != cfg_own && q.dest_addr != cfg_bcast)
                        r.action = ACT_NOT_OURS;
                    else begin
                        r.action = ACT_DELIVER;
                        r.out_dest = q.src_addr;
                        r.out_src = q.dest_addr;
                        r.out_id = q.msg_id;
                    end
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                default: begin
                    for (int i = 0; i < DEPTH && n < MAX_RETX; i++) begin
                        if (tbl_waiting[i] && (q.now_us - tbl_time[i]) > cfg_tmo) begin
                            tbl_time[i] = q.now_us;
                            r = blank_res();
                            r.action = ACT_RETX;
                            r.entry_index = 4'(i);
                            r.out_dest = tbl_dest[i];
                            r.out_src = cfg_own;
                            r.out_id = tbl_id[i];
                            expected_results.push_back(r);
                            n++;
                        end
                    end
                    if (n == 0) begin
                        r = blank_res();
                        r.action = ACT_NONE;
                        expected_results.push_back(r);
                    end
                    expected_results[$].last = 1'b1;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            n_errors++;
        end
    endtask

    // result monitor: sampled at the edge that accepts the item
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 32'(o_res), 32'd0);
            end else begin
                e = expected_results.pop_front();
                if (o_res.action !== e.action)
                    report_mismatch("action", 32'(o_res.action), 32'(e.action));
                if (o_res.entry_index !== e.entry_index)
                    report_mismatch("entry_index", 32'(o_res.entry_index),
                                    32'(e.entry_index));
                if (o_res.out_dest !== e.out_dest)
                    report_mismatch("out_dest", 32'(o_res.out_dest), 32'(e.out_dest));
                if (o_res.out_src !== e.out_src)
                    report_mismatch("out_src", 32'(o_res.out_src), 32'(e.out_src));
                if (o_res.out_id !== e.out_id)
                    report_mismatch("out_id", 32'(o_res.out_id), 32'(e.out_id));
                if (o_res.out_checksum !== e.out_checksum)
                    report_mismatch("out_checksum", 32'(o_res.out_checksum),
                                    32'(e.out_checksum));
                if (o_res.cleared_count !== e.cleared_count)
                    report_mismatch("cleared_count", 32'(o_res.cleared_count),
                                    32'(e.cleared_count));
                if (o_res.last !== e.last)
                    report_mismatch("last", 32'(o_res.last), 32'(e.last));
            end
        end
    end

    // APB write: setup then access; pready is always high
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= val;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            case (idx)
                REG_OWN:   cfg_own = val[7:0];
                REG_BCAST: cfg_bcast = val[7:0];
                default:   cfg_tmo = val;
            endcase
        end
    endtask

    // let all results drain, then the scan latency, before touching registers
    task automatic wait_idle();
        begin
            i_start <= 1'b0;
            while (expected_results.size() != 0) @(posedge i_clk);
            repeat (2 * DEPTH + 8) @(posedge i_clk);
        end
    endtask

    // present one request and hold it until accepted; start stays high
    // into the next item when no gap is drawn
    task automatic issue_request(input t_req q);
        int gap;
        begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_start <= 1'b1;
            i_req <= q;
            @(posedge i_clk);
            while (o_busy) @(posedge i_clk);
            predict_request(q);
            if (q.req_type == REQ_SEND) begin
                sent_dest.push_back(q.dest_addr);
                sent_id.push_back(q.msg_id);
                if (sent_dest.size() > 24) begin
                    void'(sent_dest.pop_front());
                    void'(sent_id.pop_front());
                end
            end
        end
    endtask

    function automatic t_req make_req(logic [1:0] kind, logic [7:0] d, logic [7:0] s,
                                      logic [7:0] id, logic [4:0] len, logic [7:0] ck,
                                      logic [31:0] now);
        t_req q;
        q.req_type = kind;
        q.dest_addr = d;
        q.src_addr = s;
        q.msg_id = id;
        q.payload_length = len;
        q.rx_checksum = ck;
        q.now_us = now;
        return q;
    endfunction

    function automatic t_res fixed_res(logic [2:0] act, logic [4:0] cnt);
        t_res r;
        r = '0;
        r.action = act;
        r.cleared_count = cnt;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic add_row(input t_req q, input bit fx, input t_res r);
        t_row w;
        begin
            w.req = q;
            w.fixed = fx;
            w.res = r;
            rows.push_back(w);
        end
    endtask

    // random request, mostly well-formed traffic around the table contents
    function automatic t_req random_req(logic [31:0] now);
        t_req q;
        int   k;
        int   pick;
        q = make_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                     8'($urandom), 5'($urandom_range(0, 31)), 8'($urandom), now);
        k = $urandom_range(0, 99);
        if (k < 35) q.req_type = REQ_SEND;
        else if (k < 55) begin
            q.req_type = REQ_ACK;
            if (sent_dest.size() != 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, sent_dest.size() - 1);
                q.src_addr = sent_dest[pick];
                q.msg_id = sent_id[pick];
            end
        end else if (k < 80) begin
            q.req_type = REQ_DATA;
            case ($urandom_range(0, 3))
                0: q.dest_addr = cfg_own;
                1: q.dest_addr = cfg_bcast;
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                q.rx_checksum = csum(q.dest_addr, q.src_addr, q.payload_length);
        end else q.req_type = REQ_TICK;
        if (q.req_type == REQ_SEND && $urandom_range(0, 3) == 0)
            q.dest_addr = 8'($urandom_range(0, 3));
        return q;
    endfunction

    initial begin
        logic [31:0] now;
        n_errors = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_dest[i] = '0;
            tbl_id[i] = '0;
            tbl_time[i] = '0;
            tbl_waiting[i] = 1'b0;
        end
        wr_pos = '0;
        cfg_own = OWN_RST;
        cfg_bcast = BCAST_RST;
        cfg_tmo = TMO_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset values
        add_row(make_req(REQ_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0, 32'hFFFF_FFFF), 1'b1,
                fixed_res(ACT_NONE, 5'd0));
        add_row(make_req(REQ_ACK, 8'd0, 8'h12, 8'h34, 5'd0, 8'd0, 32'd0), 1'b1,
                fixed_res(ACT_ACKED, 5'd0));
        add_row(make_req(REQ_DATA, 8'd39, 8'd0, 8'd1, 5'd0, 8'h00, 32'd0), 1'b1,
                fixed_res(ACT_BAD_CK, 5'd0));
        add_row(make_req(REQ_DATA, 8'd40, 8'd0, 8'd1, 5'd1, 8'd40, 32'd0), 1'b1,
                fixed_res(ACT_NOT_OURS, 5'd0));
        add_row(make_req(REQ_DATA, 8'd39, 8'hFF, 8'hFF, 5'd31, 8'h00, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_DATA, 8'd255, 8'hAA, 8'h55, 5'd25, 8'h00, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_SEND, 8'h00, 8'd0, 8'h00, 5'd0, 8'd0, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_SEND, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'hFF, 32'd100), 1'b0, '0);
        add_row(make_req(REQ_SEND, 8'h10, 8'd0, 8'h20, 5'd25, 8'd0, 32'hFFFF_FFF0),
                1'b0, '0);
        add_row(make_req(REQ_SEND, 8'h10, 8'd0, 8'h20, 5'd3, 8'd0, 32'd5), 1'b0, '0);
        add_row(make_req(REQ_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0, 32'd2000000), 1'b0, '0);
        add_row(make_req(REQ_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0, 32'd2000101), 1'b0, '0);
        add_row(make_req(REQ_ACK, 8'd0, 8'h10, 8'h20, 5'd0, 8'd0, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_ACK, 8'd0, 8'hFF, 8'hFF, 5'd0, 8'd0, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0, 32'h8000_0000), 1'b0, '0);
        for (int i = 0; i < 18; i++)
            add_row(make_req(REQ_SEND, 8'($urandom), 8'd0, 8'($urandom), 5'($urandom),
                             8'd0, 32'd0), 1'b0, '0);
        add_row(make_req(REQ_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0, 32'hFFFF_FFFF), 1'b0, '0);

        foreach (rows[i]) begin
            issue_request(rows[i].req);
            if (rows[i].fixed) begin
                // typed-in result is what the block must give
                if (expected_results[$] != rows[i].res)
                    report_mismatch("directed row", i, 32'd0);
                expected_results[$] = rows[i].res;
            end
        end
        wait_idle();

        // random phases across register settings, extremes among them
        now = 32'd0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_register(REG_OWN, 32'd0);
                    write_register(REG_BCAST, 32'd0);
                    write_register(REG_TMO, 32'd0);
                end
                1: begin
                    write_register(REG_OWN, 32'd255);
                    write_register(REG_BCAST, 32'd255);
                    write_register(REG_TMO, 32'hFFFF_FFFF);
                end
                2: begin
                    write_register(REG_OWN, 32'($urandom));
                    write_register(REG_BCAST, 32'($urandom));
                    write_register(REG_TMO, 32'd50);
                end
                3: begin
                    write_register(REG_OWN, 32'(OWN_RST));
                    write_register(REG_BCAST, 32'hFFFF_FF00 | BCAST_RST);
                    write_register(REG_TMO, 32'hFFFF_FFFE);
                end
                default: begin
                    write_register(REG_OWN, 32'($urandom));
                    write_register(REG_BCAST, 32'($urandom));
                    write_register(REG_TMO, 32'($urandom_range(0, 400)));
                end
            endcase
            for (int k = 0; k < 27; k++) begin
                if ($urandom_range(0, 9) == 0) now = $urandom;
                else now = now + $urandom_range(0, 120);
                issue_request(random_req(now));
                if (k == 17 && ph == 2) begin
                    i_start <= 1'b0;
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
            end
            wait_idle();
        end

        // final drain
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
